// File: hw/rtl/max_gap_bucket_engine_unit_defines.svh
// Assertion macros for the max gap bucket engine.
// Depends on nothing; included by the top level.
`ifndef MAX_GAP_BUCKET_ENGINE_UNIT_DEFINES_SVH
`define MAX_GAP_BUCKET_ENGINE_UNIT_DEFINES_SVH
`define MGB_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
`define MGB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/mgb_pkg.sv
// Shared types and constants of the max gap bucket engine.
// No dependencies.
package mgb_pkg;
  localparam int MaxValues = 16;
  localparam int IdxW = $clog2(MaxValues);
  localparam int CntW = $clog2(MaxValues + 1);
  localparam int BktN = MaxValues - 1;
  localparam int BktW = $clog2(BktN);
  localparam int DivW = 32 + CntW;
  localparam int DivCntW = $clog2(DivW + 1);

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [31:0] gap;
    logic        trunc;
  } res_t;

  // queue entry between front and back: one finished set
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [31:0]     vmin;
    logic [31:0]     vmax;
    logic            trunc;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_RD, BK_LD, BK_DIV, BK_PLACE, BK_SCAN, BK_OUT
  } bk_state_t;
endpackage

// File: hw/rtl/mgb_if.sv
// Valid/ready channel carrying one word.
// No dependencies.
interface mgb_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/mgb_ram.sv
// Generic single-port write, single-port registered-read RAM.
// No dependencies.
module mgb_ram #(parameter int Width = 32, parameter int Depth = 16) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/mgb_front.sv
// Front end: stores values, tracks min/max, posts a job per set.
// Depends on mgb_pkg.
module mgb_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  mgb_pkg::word_t          in_word,
  input  logic                    job_full,
  output logic                    job_push,
  output mgb_pkg::job_t           job,
  output logic                    st_we,
  output logic [mgb_pkg::IdxW-1:0] st_waddr,
  output logic [31:0]             st_wdata,
  input  logic                    bank_busy
);
  logic [mgb_pkg::CntW-1:0] cnt_r;
  logic signed [31:0] min_r, max_r;
  logic ovf_r;
  logic acc, room;
  logic signed [31:0] v, nmin, nmax;

  assign in_ready = !job_full && !bank_busy;
  assign acc = in_valid && in_ready;
  assign v = in_word.value;
  assign room = (cnt_r < mgb_pkg::CntW'(mgb_pkg::MaxValues));
  assign nmin = (room && v < min_r) ? v : min_r;
  assign nmax = (room && v > max_r) ? v : max_r;
  assign st_we = acc && room;
  assign st_waddr = cnt_r[mgb_pkg::IdxW-1:0];
  assign st_wdata = v;
  assign job_push = acc && in_word.last;
  assign job.count = room ? cnt_r + 1'b1 : cnt_r;
  assign job.vmin = nmin;
  assign job.vmax = nmax;
  assign job.trunc = ovf_r || !room;

  always_ff @(posedge clk) begin
    if (!rst_n || job_push) begin
      cnt_r <= '0;
      min_r <= 32'sh7fffffff;
      max_r <= 32'sh80000000;
      ovf_r <= 1'b0;
    end else if (acc) begin
      if (room) cnt_r <= cnt_r + 1'b1;
      min_r <= nmin;
      max_r <= nmax;
      ovf_r <= ovf_r || !room;
    end
  end
endmodule

// File: hw/rtl/mgb_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on mgb_pkg.
module mgb_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [mgb_pkg::DivW-1:0] num,
  input  logic [32:0]              den,
  output logic                     done,
  output logic [mgb_pkg::DivW-1:0] quo
);
  logic [mgb_pkg::DivW-1:0] q_r;
  logic [33:0] rem_r;
  logic [32:0] den_r;
  logic [mgb_pkg::DivCntW-1:0] n_r;
  logic busy_r;
  logic [33:0] sh;

  assign sh = {rem_r[32:0], q_r[mgb_pkg::DivW-1]};
  assign done = busy_r && (n_r == '0);
  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      n_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      n_r <= mgb_pkg::DivCntW'(mgb_pkg::DivW);
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      n_r <= n_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r && n_r != '0) begin
      if (sh >= {1'b0, den_r}) begin
        rem_r <= sh - {1'b0, den_r};
        q_r <= {q_r[mgb_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r <= {q_r[mgb_pkg::DivW-2:0], 1'b0};
      end
    end
  end
endmodule

// File: hw/rtl/mgb_back.sv
// Back end: buckets stored values, scans buckets, emits the gap.
// Depends on mgb_pkg, mgb_div.
module mgb_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  mgb_pkg::job_t           job,
  output logic                    job_pop,
  output logic [mgb_pkg::IdxW-1:0] st_raddr,
  input  logic [31:0]             st_rdata,
  output logic                    bank_busy,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mgb_pkg::res_t           out_word
);
  mgb_pkg::bk_state_t st_r, st_nxt;
  mgb_pkg::job_t j_r;
  logic [mgb_pkg::IdxW-1:0] i_r;
  logic signed [31:0] v_r;
  logic [mgb_pkg::BktW-1:0] b_r;
  logic signed [31:0] lo_r [mgb_pkg::BktN];
  logic signed [31:0] hi_r [mgb_pkg::BktN];
  logic [mgb_pkg::BktN-1:0] used_r;
  logic signed [32:0] left_r;
  logic have_r;
  logic [31:0] best_r;
  logic ov_r;
  logic [31:0] gap_r;
  logic tr_r;
  logic div_start, div_done;
  logic [mgb_pkg::DivW-1:0] num, quo;
  logic [32:0] span, off;
  logic [mgb_pkg::CntW-1:0] nm1;
  logic [mgb_pkg::DivW-1:0] idx;
  logic trivial, last_i;
  logic signed [32:0] d;

  assign span = 33'($signed(j_r.vmax)) - 33'($signed(j_r.vmin));
  // registered store read is valid in BK_LD
  assign off = 33'($signed(st_rdata)) - 33'($signed(j_r.vmin));
  assign nm1 = j_r.count - 1'b1;
  assign num = mgb_pkg::DivW'(off) * mgb_pkg::DivW'(nm1);
  assign idx = (quo >= mgb_pkg::DivW'(nm1)) ? mgb_pkg::DivW'(nm1 - 1'b1) : quo;
  assign trivial = (j_r.count < 2) || ($signed(j_r.vmax) <= $signed(j_r.vmin));
  assign last_i = (mgb_pkg::CntW'(i_r) + 1'b1 >= j_r.count);
  assign d = 33'(signed'(lo_r[i_r[mgb_pkg::BktW-1:0]])) - left_r;

  assign st_raddr = i_r;
  assign bank_busy = (st_r != mgb_pkg::BK_IDLE) || job_valid;
  assign job_pop = (st_r == mgb_pkg::BK_OUT) && !ov_r;
  assign out_valid = ov_r;
  assign out_word.gap = gap_r;
  assign out_word.trunc = tr_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mgb_pkg::BK_IDLE: if (job_valid) st_nxt = mgb_pkg::BK_RD;
      mgb_pkg::BK_RD: st_nxt = trivial ? mgb_pkg::BK_OUT : mgb_pkg::BK_LD;
      mgb_pkg::BK_LD: st_nxt = mgb_pkg::BK_DIV;
      mgb_pkg::BK_DIV: if (div_done) st_nxt = mgb_pkg::BK_PLACE;
      mgb_pkg::BK_PLACE: st_nxt = last_i ? mgb_pkg::BK_SCAN : mgb_pkg::BK_RD;
      mgb_pkg::BK_SCAN:
        if (32'(i_r) + 2 >= 32'(j_r.count) ||
            32'(i_r) + 1 >= mgb_pkg::BktN) st_nxt = mgb_pkg::BK_OUT;
      mgb_pkg::BK_OUT: if (!ov_r) st_nxt = mgb_pkg::BK_IDLE;
      default: st_nxt = mgb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    div_start = (st_r == mgb_pkg::BK_LD);
  end

  mgb_div u_div (.clk, .rst_n, .start(div_start), .num, .den(span),
    .done(div_done), .quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mgb_pkg::BK_IDLE;
      ov_r <= 1'b0;
      used_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (st_r == mgb_pkg::BK_OUT && !ov_r) begin
        ov_r <= 1'b1;
        used_r <= '0;
      end
      if (st_r == mgb_pkg::BK_PLACE && !used_r[b_r]) used_r[b_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      mgb_pkg::BK_IDLE: begin
        j_r <= job;
        i_r <= '0;
        have_r <= 1'b0;
        best_r <= '0;
      end
      mgb_pkg::BK_LD: v_r <= st_rdata;
      mgb_pkg::BK_DIV: b_r <= mgb_pkg::BktW'(idx);
      mgb_pkg::BK_PLACE: begin
        if (!used_r[b_r] || v_r < lo_r[b_r]) lo_r[b_r] <= v_r;
        if (!used_r[b_r] || v_r > hi_r[b_r]) hi_r[b_r] <= v_r;
        i_r <= last_i ? '0 : i_r + 1'b1;
      end
      mgb_pkg::BK_SCAN: begin
        if (used_r[i_r[mgb_pkg::BktW-1:0]]) begin
          if (have_r && d > 33'(signed'({1'b0, best_r}))) best_r <= d[31:0];
          left_r <= 33'(signed'(hi_r[i_r[mgb_pkg::BktW-1:0]]));
          have_r <= 1'b1;
        end
        i_r <= i_r + 1'b1;
      end
      mgb_pkg::BK_OUT: if (!ov_r) begin
        gap_r <= trivial ? '0 : best_r;
        tr_r <= j_r.trunc;
      end
      default: ;
    endcase
  end
endmodule

// File: hw/rtl/max_gap_bucket_engine_unit.sv
// Maximum gap engine: one value word per cycle is loaded while the back end is
// idle and no job is queued; after the word marked last, each stored value
// costs one read, one load, a bit-serial division and one placement, then the
// buckets are scanned and the gap is emitted. The bit-serial division dominates
// the time a set takes. Capacity is 16 values; extra words are dropped and
// flagged.
`include "max_gap_bucket_engine_unit_defines.svh"
module max_gap_bucket_engine_unit (
  input logic clk,
  input logic rst_n,
  mgb_if.sink   in_ch,
  mgb_if.source out_ch
);
  logic job_full, job_push, job_pop, q_valid, bank_busy;
  mgb_pkg::job_t job_in, job_q;
  logic st_we;
  logic [mgb_pkg::IdxW-1:0] st_waddr, st_raddr;
  logic [31:0] st_wdata, st_rdata;

  mgb_front u_front (.clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_word(in_ch.data), .job_full, .job_push, .job(job_in),
    .st_we, .st_waddr, .st_wdata, .bank_busy);

  // one-entry job queue
  always_ff @(posedge clk) begin
    if (!rst_n) q_valid <= 1'b0;
    else if (job_push) q_valid <= 1'b1;
    else if (job_pop) q_valid <= 1'b0;
    if (job_push) job_q <= job_in;
  end
  assign job_full = q_valid;

  mgb_ram #(.Width(32), .Depth(mgb_pkg::MaxValues)) u_store (.clk, .we(st_we),
    .waddr(st_waddr), .wdata(st_wdata), .raddr(st_raddr), .rdata(st_rdata));

  mgb_back u_back (.clk, .rst_n, .job_valid(q_valid), .job(job_q), .job_pop,
    .st_raddr, .st_rdata, .bank_busy, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_word(out_ch.data));

  `MGB_ASSERT_IMPL(a_no_load_busy, clk, rst_n, bank_busy, !in_ch.ready, "load while busy")
  `MGB_ASSERT_NEXT(a_push_fills, clk, rst_n, job_push, q_valid, "job lost")
endmodule

// File: dv/max_gap_bucket_engine_unit_chk.sv
// Checker for the max gap bucket engine: watches the value and result channels,
// predicts each set's gap and truncation flag, and compares them in order.
// Depends on mgb_pkg and the mgb_if interface.
module max_gap_bucket_engine_unit_chk (
  input  logic clk,
  input  logic rst_n,
  mgb_if       in_mon,
  mgb_if       out_mon,
  output int   mismatches,
  output int   gaps_waiting,
  output int   sets_seen,
  output int   trunc_seen
);
  logic signed [31:0] set_vals [mgb_pkg::MaxValues];
  int                 set_cnt;
  logic signed [31:0] set_min;
  logic signed [31:0] set_max;
  logic               set_ovf;
  mgb_pkg::res_t      gap_q[$];

  function automatic logic [31:0] widest_gap();
    int     n;
    int     idx;
    longint span;
    longint off;
    longint prev_hi;
    longint best;
    bit     have_prev;
    bit     used [mgb_pkg::BktN];
    longint lo [mgb_pkg::BktN];
    longint hi [mgb_pkg::BktN];
    n = set_cnt;
    best = 0;
    have_prev = 0;
    prev_hi = 0;
    if (n < 2 || set_max <= set_min) return 32'd0;
    span = longint'(set_max) - longint'(set_min);
    for (int i = 0; i < mgb_pkg::BktN; i++) used[i] = 0;
    for (int i = 0; i < n; i++) begin
      off = longint'(set_vals[i]) - longint'(set_min);
      idx = int'((off * (n - 1)) / span);
      if (idx >= n - 1) idx = n - 2;
      if (!used[idx]) begin
        used[idx] = 1;
        lo[idx] = set_vals[i];
        hi[idx] = set_vals[i];
      end else begin
        if (set_vals[i] < lo[idx]) lo[idx] = set_vals[i];
        if (set_vals[i] > hi[idx]) hi[idx] = set_vals[i];
      end
    end
    for (int i = 0; i < n - 1; i++) begin
      if (used[i]) begin
        if (have_prev && lo[i] - prev_hi > best) best = lo[i] - prev_hi;
        prev_hi = hi[i];
        have_prev = 1;
      end
    end
    return best[31:0];
  endfunction

  assign gaps_waiting = gap_q.size();

  always @(posedge clk) begin
    mgb_pkg::word_t w;
    mgb_pkg::res_t  exp_r;
    mgb_pkg::res_t  got;
    if (!rst_n) begin
      set_cnt = 0;
      set_min = 32'sh7FFFFFFF;
      set_max = 32'sh80000000;
      set_ovf = 0;
      mismatches <= 0;
      sets_seen <= 0;
      trunc_seen <= 0;
      gap_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        w = in_mon.data;
        if (set_cnt < mgb_pkg::MaxValues) begin
          set_vals[set_cnt] = w.value;
          set_cnt = set_cnt + 1;
          if ($signed(w.value) < set_min) set_min = w.value;
          if ($signed(w.value) > set_max) set_max = w.value;
        end else begin
          set_ovf = 1;
        end
        if (w.last) begin
          exp_r.gap = widest_gap();
          exp_r.trunc = set_ovf;
          gap_q.push_back(exp_r);
          sets_seen <= sets_seen + 1;
          if (set_ovf) trunc_seen <= trunc_seen + 1;
          set_cnt = 0;
          set_min = 32'sh7FFFFFFF;
          set_max = 32'sh80000000;
          set_ovf = 0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (gap_q.size() == 0) begin
          $display("%0t: result word with nothing expected: gap %h trunc %b",
                   $time, got.gap, got.trunc);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = gap_q.pop_front();
          if (got.gap !== exp_r.gap || got.trunc !== exp_r.trunc) begin
            $display("%0t: mismatch: expected gap %h trunc %b, got gap %h trunc %b",
                     $time, exp_r.gap, exp_r.trunc, got.gap, got.trunc);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

// File: dv/tb_max_gap_bucket_engine_unit.sv
// Top of the max gap bucket engine bench: clock, reset, value stimulus and
// result back-pressure; the verdict comes from max_gap_bucket_engine_unit_chk.
// Depends on mgb_pkg, mgb_if and the block itself.
module tb_max_gap_bucket_engine_unit;
  logic clk = 0;
  logic rst_n = 0;
  int   tx_idle = 0;
  int   rx_stall = 0;
  bit   hold_req = 0;
  bit   hold_used = 0;
  int   hold_left = 0;
  int   words_sent = 0;
  int   mismatches;
  int   gaps_waiting;
  int   sets_seen;
  int   trunc_seen;

  mgb_if #(.T(mgb_pkg::word_t)) in_ch ();
  mgb_if #(.T(mgb_pkg::res_t))  out_ch ();

  max_gap_bucket_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  max_gap_bucket_engine_unit_chk chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches   (mismatches),
    .gaps_waiting (gaps_waiting),
    .sets_seen    (sets_seen),
    .trunc_seen   (trunc_seen)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  // receiver: random stalls, plus one long hold-off to fill the block
  always @(posedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used <= 1;
      hold_left <= 1500;
      out_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= rx_stall);
    end
  end

  task automatic send_word(input logic [31:0] v, input logic last);
    mgb_pkg::word_t w;
    w.value = v;
    w.last = last;
    if ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_set(input int len, input int mode);
    logic [31:0] base;
    logic [31:0] v;
    base = $urandom();
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = $urandom();
        1: v = base + $urandom_range(64);
        2: v = base;
        default: v = $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
                                      : 32'h80000000 + $urandom_range(3);
      endcase
      send_word(v, i == len - 1);
    end
  endtask

  initial begin
    int len;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: single value, full range, equal values, small set, overflow
    send_word(32'h12345678, 1);
    send_word(32'h80000000, 0);
    send_word(32'h7FFFFFFF, 1);
    repeat (3) send_word(32'h00050000, 0);
    send_word(32'h00050000, 1);
    send_word(32'h00000000, 0);
    send_word(32'h000A0000, 0);
    send_word(32'hFFFD0000, 1);
    for (int i = 0; i < 16; i++) send_word($urandom(), 0);
    send_word($urandom(), 1);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle = 0;  rx_stall = 0;  end
        1: begin tx_idle = 56; rx_stall = 0;  end
        2: begin tx_idle = 0;  rx_stall = 56; end
        default: begin tx_idle = 15; rx_stall = 15; end
      endcase
      if (ph == 0) hold_req = 1;
      while (words_sent < 25 + 300 * (ph + 1)) begin
        case ($urandom_range(9))
          0:       len = $urandom_range(20, 17);
          1, 2:    len = $urandom_range(16, 9);
          default: len = $urandom_range(8, 1);
        endcase
        send_set(len, $urandom_range(9) < 6 ? 0 : $urandom_range(3, 1));
      end
    end
    in_ch.valid <= 0;
    for (int i = 0; i < 200000 && gaps_waiting != 0; i++) @(posedge clk);
    repeat (800) @(posedge clk);
    $display("Sent %0d value words in %0d sets, %0d of them truncated;",
             words_sent, sets_seen, trunc_seen);
    $display("idle and stall mixes covered, with one long result hold-off.");
    if (mismatches == 0 && gaps_waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (gaps_waiting != 0) $display("%0t: %0d results never arrived", $time, gaps_waiting);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mgb_pkg.sv
hw/rtl/mgb_if.sv
hw/rtl/mgb_ram.sv
hw/rtl/mgb_front.sv
hw/rtl/mgb_div.sv
hw/rtl/mgb_back.sv
hw/rtl/max_gap_bucket_engine_unit.sv
dv/max_gap_bucket_engine_unit_chk.sv
dv/tb_max_gap_bucket_engine_unit.sv
